// ===== sv/fct_pkg.sv =====
// fct_pkg: shared constants, codes and the item record for the frustum cull test
// depends on nothing; imported by fct_cell, frustum_cull_test and frustum_cull_test_test
`timescale 1ns / 1ps

package fct_pkg;

  // coordinate width (signed Q11.4 at 16 bits)
  localparam int COORD_BITS = 16;

  // plane layout: nx, ny, nz, d packed at 16 bits each
  localparam int PLANE_COUNT = 6;
  localparam int PLANE_IDX_W = 3;
  localparam int PLANE_W     = 64;
  localparam int COEF_W      = 16;
  localparam int NORMAL_FRAC = 14;
  localparam int RADIUS_W    = 15;

  // arithmetic widths: product, scaled d term, and a sum with headroom
  localparam int PROD_W   = COORD_BITS + COEF_W;
  localparam int DTERM_W  = COEF_W + NORMAL_FRAC;
  localparam int SUM_BASE = (PROD_W > DTERM_W) ? PROD_W : DTERM_W;
  localparam int SUM_W    = SUM_BASE + 2;

  // stream widths
  localparam int ACTION_W   = 2;
  localparam int VERDICT_W  = 2;
  localparam int S_FIELDS_W = 3 * COORD_BITS + RADIUS_W;
  localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_DATA_W   = 8;

  // configuration port
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_POINT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SPHERE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_BOX    = 2'd2;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_INTERSECTS = 2'd2;

  // one item as it travels down the row of plane cells
  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [COORD_BITS-1:0] pos_z;
    logic [RADIUS_W-1:0]   radius;
    logic                  last_corner;
    logic                  pass;     // point or sphere inside every plane so far
    logic                  acc_any;  // box: every plane so far has a corner inside
    logic                  acc_all;  // box: every corner inside every plane so far
  } fct_item_t;

endpackage

// ===== sv/fct_cell.sv =====
// fct_cell: one plane of the frustum, a two-stage slice of the cell row
// holds its plane and box flags; depends on fct_pkg
`timescale 1ns / 1ps

module fct_cell import fct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               plane_we,
  input  logic [PLANE_W-1:0] plane_wdata,
  output logic [PLANE_W-1:0] plane,
  input  logic               in_valid,
  output logic               in_ready,
  input  fct_item_t          in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output fct_item_t          out_item
);

  logic                     a_valid;
  fct_item_t                a_item;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  logic                     a_ready;
  logic                     a_move;
  logic                     in_move;

  logic                     any_in;
  logic                     all_in;
  logic                     any_next;
  logic                     all_next;
  fct_item_t                item_next;

  logic signed [COEF_W-1:0] nx;
  logic signed [COEF_W-1:0] ny;
  logic signed [COEF_W-1:0] nz;
  logic signed [COEF_W-1:0] dd;
  logic signed [SUM_W-1:0]  d_term;
  logic signed [SUM_W-1:0]  rad_term;
  logic signed [SUM_W-1:0]  dist_sum;
  logic signed [SUM_W-1:0]  limit;
  logic                     ge;
  logic                     any_new;
  logic                     all_new;

  assign nx = plane[15:0];
  assign ny = plane[31:16];
  assign nz = plane[47:32];
  assign dd = plane[63:48];

  // handshake: a stage moves when it is empty or its successor moves
  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;
  assign in_move  = in_valid && in_ready;
  assign a_move   = a_valid && a_ready;

  // plane register, valid bits and box flags
  always_ff @(posedge clk) begin
    if (rst) begin
      plane     <= '0;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      any_in    <= 1'b0;
      all_in    <= 1'b1;
    end else begin
      if (plane_we) begin
        plane <= plane_wdata;
      end
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_ready) begin
        out_valid <= a_valid;
      end
      if (a_move) begin
        any_in <= any_next;
        all_in <= all_next;
      end
    end
  end

  // stage a: the three products of normal and position
  always_ff @(posedge clk) begin
    if (in_move) begin
      a_item <= in_item;
      prod_x <= $signed(in_item.pos_x) * nx;
      prod_y <= $signed(in_item.pos_y) * ny;
      prod_z <= $signed(in_item.pos_z) * nz;
    end
  end

  // stage b: distance, compare against the limit
  assign d_term   = {{(SUM_W-DTERM_W){dd[COEF_W-1]}}, dd, {NORMAL_FRAC{1'b0}}};
  assign rad_term = {{(SUM_W-RADIUS_W-NORMAL_FRAC){1'b0}}, a_item.radius,
                     {NORMAL_FRAC{1'b0}}};
  assign dist_sum = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z) + d_term;
  assign limit    = (a_item.action == ACT_SPHERE) ? -rad_term : '0;
  assign ge       = dist_sum >= limit;
  assign any_new  = any_in | ge;
  assign all_new  = all_in & ge;

  // fold this plane into the item and the box flags
  always_comb begin
    item_next = a_item;
    any_next  = any_in;
    all_next  = all_in;
    case (a_item.action)
      ACT_POINT, ACT_SPHERE: begin
        item_next.pass = a_item.pass & ge;
      end
      ACT_BOX: begin
        if (a_item.last_corner) begin
          item_next.acc_any = a_item.acc_any & any_new;
          item_next.acc_all = a_item.acc_all & all_new;
          any_next          = 1'b0;
          all_next          = 1'b1;
        end else begin
          any_next = any_new;
          all_next = all_new;
        end
      end
      default: begin
        item_next = a_item;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== sv/frustum_cull_test.sv =====
// frustum_cull_test: six-plane view frustum test for points, spheres and boxes
// a row of six fct_cell slices plus an output register; depends on fct_pkg and fct_cell
//
//   channel   signals                                payload
//   s_axis    tvalid tready tdata tuser tlast        position, radius, action, last corner
//   m_axis    tvalid tready tdata                    verdict
//   apb       psel penable pwrite paddr pwdata ...   six 64-bit planes at 8*i
//
// one item per cycle while m_axis does not stall; each result passes two stages
// per plane cell, six cells, then the output register
// reset clears all valid bits and the planes, and resets the box flags
// a stall on m_axis backs up one stage at a time; empty stages keep filling, so
// input is taken while a result waits
`timescale 1ns / 1ps

module frustum_cull_test import fct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // s_axis_tdata: pos_x, pos_y, pos_z, radius, zero fill (lowest bit up)
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_DATA_W-1:0]   s_axis_tdata,
  // s_axis_tuser: action
  input  logic [ACTION_W-1:0]   s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // m_axis_tdata: verdict, zero fill (lowest bit up)
  output logic [M_DATA_W-1:0]   m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                   chain_valid [PLANE_COUNT+1];
  logic                   chain_ready [PLANE_COUNT+1];
  fct_item_t              chain_item  [PLANE_COUNT+1];
  logic [PLANE_W-1:0]     planes      [PLANE_COUNT];
  logic [PLANE_COUNT-1:0] plane_we;
  logic [PLANE_IDX_W-1:0] cfg_idx;
  logic                   cfg_write;
  fct_item_t              tail;
  logic                   has_result;
  logic [VERDICT_W-1:0]   verdict;
  logic [VERDICT_W-1:0]   verdict_next;

  // register port: always ready, planes at 8-byte steps
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:3];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    plane_we = '0;
    if (cfg_write && (cfg_idx < PLANE_IDX_W'(PLANE_COUNT))) begin
      plane_we[cfg_idx] = 1'b1;
    end
  end

  assign prdata = (cfg_idx < PLANE_IDX_W'(PLANE_COUNT)) ? planes[cfg_idx] : '0;

  // unpack the input transfer into the head of the row
  assign chain_valid[0]          = s_axis_tvalid;
  assign s_axis_tready           = chain_ready[0];
  assign chain_item[0].action      = s_axis_tuser;
  assign chain_item[0].pos_x       = s_axis_tdata[COORD_BITS-1:0];
  assign chain_item[0].pos_y       = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign chain_item[0].pos_z       = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign chain_item[0].radius      = s_axis_tdata[S_FIELDS_W-1:3*COORD_BITS];
  assign chain_item[0].last_corner = s_axis_tlast;
  assign chain_item[0].pass        = 1'b1;
  assign chain_item[0].acc_any     = 1'b1;
  assign chain_item[0].acc_all     = 1'b1;

  // row of plane cells
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_cell
    fct_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .plane_we    (plane_we[p]),
      .plane_wdata (pwdata),
      .plane       (planes[p]),
      .in_valid    (chain_valid[p]),
      .in_ready    (chain_ready[p]),
      .in_item     (chain_item[p]),
      .out_valid   (chain_valid[p+1]),
      .out_ready   (chain_ready[p+1]),
      .out_item    (chain_item[p+1])
    );
  end

  // tail of the row: items without a result are dropped here
  assign tail                     = chain_item[PLANE_COUNT];
  assign chain_ready[PLANE_COUNT] = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    has_result   = 1'b0;
    verdict_next = VERDICT_OUTSIDE;
    case (tail.action)
      ACT_POINT, ACT_SPHERE: begin
        has_result   = 1'b1;
        verdict_next = tail.pass ? VERDICT_INSIDE : VERDICT_OUTSIDE;
      end
      ACT_BOX: begin
        has_result = tail.last_corner;
        if (!tail.acc_any) begin
          verdict_next = VERDICT_OUTSIDE;
        end else if (tail.acc_all) begin
          verdict_next = VERDICT_INSIDE;
        end else begin
          verdict_next = VERDICT_INTERSECTS;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (chain_ready[PLANE_COUNT]) begin
      m_axis_tvalid <= chain_valid[PLANE_COUNT] && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[PLANE_COUNT] && chain_valid[PLANE_COUNT]) begin
      verdict <= verdict_next;
    end
  end

  assign m_axis_tdata = {{(M_DATA_W-VERDICT_W){1'b0}}, verdict};

endmodule

// ===== tb/frustum_cull_test_test.sv =====
// frustum_cull_test_test: self-checking bench for the six-plane frustum cull block
// drives the stream and config ports and checks every verdict against its typed value or its own predictor
// depends on fct_pkg and frustum_cull_test
`timescale 1ns / 1ps

module frustum_cull_test_test;
  import fct_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int     FREE         = -1;          // no typed verdict, use the predictor
  localparam longint NORMAL_ONE   = longint'(1) << NORMAL_FRAC;
  localparam int     UNIT         = 1 << NORMAL_FRAC;
  localparam int     HALF         = 160;         // cube half size, 10.0 in Q11.4
  localparam int     RESET_CASES  = 4;           // directed rows run on the reset planes
  localparam int     RANDOM_ITEMS = 1150;
  localparam int     PHASES       = 6;
  localparam int     DRAIN_CYCLES = 30;
  localparam int     CYCLE_LIMIT  = 400000;

  typedef enum int {REG_NEAR, REG_FAR, REG_LEFT, REG_RIGHT, REG_TOP, REG_BOTTOM} plane_reg_e;
  typedef enum int {PLANES_CUBE, PLANES_TILTED, PLANES_RANDOM, PLANES_EXTREME} plane_mode_e;

  typedef struct {
    logic [ACTION_W-1:0] act;
    int                  x, y, z, r;
    bit                  last;
    int                  want;
  } cull_case_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // s_axis_tdata: pos_x, pos_y, pos_z, radius, zero fill (lowest bit up)
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  // s_axis_tuser: action
  logic [ACTION_W-1:0]   s_axis_tuser = ACT_POINT;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // m_axis_tdata: verdict, zero fill (lowest bit up)
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state: plane copies and box corner flags
  logic [PLANE_W-1:0]     plane_set [PLANE_COUNT] = '{default: '0};
  logic [PLANE_COUNT-1:0] corner_any = '0;
  logic [PLANE_COUNT-1:0] corner_all = '1;

  logic [VERDICT_W-1:0] verdict_q [$];
  cull_case_t           dir_cases [$];
  plane_mode_e          phase_modes [PHASES] = '{PLANES_CUBE, PLANES_RANDOM, PLANES_TILTED,
                                                 PLANES_EXTREME, PLANES_TILTED, PLANES_RANDOM};

  int drv_want = FREE;
  int send_idle = 0;
  int recv_idle = 0;
  int cycle_count = 0;
  int failures = 0;
  int n_checked = 0;
  int n_points = 0;
  int n_spheres = 0;
  int n_boxes = 0;
  int n_settings = 0;

  frustum_cull_test uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk = ~clk;

  // signed distance of a position to one plane, Q.18
  function automatic longint plane_dist(input int p, input longint x, y, z);
    longint nx, ny, nz, d;
    nx = longint'($signed(plane_set[p][COEF_W-1:0]));
    ny = longint'($signed(plane_set[p][2*COEF_W-1:COEF_W]));
    nz = longint'($signed(plane_set[p][3*COEF_W-1:2*COEF_W]));
    d  = longint'($signed(plane_set[p][4*COEF_W-1:3*COEF_W]));
    return nx * x + ny * y + nz * z + d * NORMAL_ONE;
  endfunction

  // expected verdict for one item; box corners update the flags
  function automatic void cull_predict(input logic [ACTION_W-1:0] act,
                                       input logic [S_DATA_W-1:0] data, input logic last,
                                       output logic has, output logic [VERDICT_W-1:0] verdict);
    longint px, py, pz, lim;
    logic   all_in;
    px = longint'($signed(data[COORD_BITS-1:0]));
    py = longint'($signed(data[2*COORD_BITS-1:COORD_BITS]));
    pz = longint'($signed(data[3*COORD_BITS-1:2*COORD_BITS]));
    has = 1'b0;
    verdict = VERDICT_OUTSIDE;
    if (act == ACT_POINT || act == ACT_SPHERE) begin
      lim = 0;
      if (act == ACT_SPHERE)
        lim = -(longint'(data[3*COORD_BITS+RADIUS_W-1:3*COORD_BITS]) * NORMAL_ONE);
      all_in = 1'b1;
      for (int p = 0; p < PLANE_COUNT; p++)
        if (plane_dist(p, px, py, pz) < lim) all_in = 1'b0;
      has = 1'b1;
      verdict = all_in ? VERDICT_INSIDE : VERDICT_OUTSIDE;
    end else if (act == ACT_BOX) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        if (plane_dist(p, px, py, pz) < 0) corner_all[p] = 1'b0;
        else corner_any[p] = 1'b1;
      end
      if (last) begin
        has = 1'b1;
        if (corner_any != '1) verdict = VERDICT_OUTSIDE;
        else if (corner_all == '1) verdict = VERDICT_INSIDE;
        else verdict = VERDICT_INTERSECTS;
        corner_any = '0;
        corner_all = '1;
      end
    end
  endfunction

  function automatic logic [PLANE_W-1:0] pack_plane(input int nx, ny, nz, d);
    return {COEF_W'(d), COEF_W'(nz), COEF_W'(ny), COEF_W'(nx)};
  endfunction

  function automatic int jit(input int j);
    return int'($urandom_range(0, 2 * j)) - j;
  endfunction

  // mostly near the frustum, sometimes anywhere in range
  function automatic int rand_coord();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 1200)) - 600;
    return int'($urandom);
  endfunction

  function automatic int rand_radius();
    if ($urandom_range(0, 99) < 80) return $urandom_range(0, 400);
    return $urandom_range(0, 32767);
  endfunction

  function automatic void add_case(input logic [ACTION_W-1:0] act, input int x, y, z, r,
                                   input bit last, input int want);
    cull_case_t c;
    c = '{act, x, y, z, r, last, want};
    dir_cases.push_back(c);
  endfunction

  // config write: setup then access, then back to idle
  task automatic plane_write(input int idx, input logic [PLANE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    plane_set[idx] = value;
    @(posedge clk);
  endtask

  task automatic load_planes(input plane_mode_e mode);
    int j;
    n_settings++;
    case (mode)
      PLANES_CUBE, PLANES_TILTED: begin
        j = (mode == PLANES_TILTED) ? 3000 : 0;
        plane_write(REG_NEAR,   pack_plane(jit(j), jit(j), UNIT + jit(j), HALF + jit(j)));
        plane_write(REG_FAR,    pack_plane(jit(j), jit(j), -UNIT + jit(j), HALF + jit(j)));
        plane_write(REG_LEFT,   pack_plane(UNIT + jit(j), jit(j), jit(j), HALF + jit(j)));
        plane_write(REG_RIGHT,  pack_plane(-UNIT + jit(j), jit(j), jit(j), HALF + jit(j)));
        plane_write(REG_TOP,    pack_plane(jit(j), -UNIT + jit(j), jit(j), HALF + jit(j)));
        plane_write(REG_BOTTOM, pack_plane(jit(j), UNIT + jit(j), jit(j), HALF + jit(j)));
      end
      PLANES_RANDOM: begin
        for (int p = 0; p < PLANE_COUNT; p++) plane_write(p, {$urandom, $urandom});
      end
      default: begin
        // coefficient extremes: largest positive, most negative, all ones
        for (int p = 0; p < PLANE_COUNT; p++)
          plane_write(p, (p % 3 == 0) ? 64'h7FFF_7FFF_7FFF_7FFF :
                         (p % 3 == 1) ? 64'h8000_8000_8000_8000 : '1);
      end
    endcase
  endtask

  // present one item and hold it until the transfer
  task automatic send_item(input logic [ACTION_W-1:0] act, input int x, y, z, r,
                           input bit last, input int want);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'({RADIUS_W'(r), COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)});
    s_axis_tuser  <= act;
    s_axis_tlast  <= last;
    drv_want      <= want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending and let every pending verdict come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random mix: points, spheres, box runs, some noise corners and unused codes
  task automatic send_random(input int n);
    int sent, pick, len, cx, cy, cz, ex, ey, ez;
    bit noisy;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(ACT_UNUSED, rand_coord(), rand_coord(), rand_coord(), rand_radius(),
                  1'($urandom_range(0, 1)), FREE);
      end else if (pick < 55) begin
        send_item((pick < 30) ? ACT_POINT : ACT_SPHERE, rand_coord(), rand_coord(),
                  rand_coord(), rand_radius(), 1'($urandom_range(0, 1)), FREE);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) < 7) ? 8 : $urandom_range(1, 12);
        cx = rand_coord();
        cy = rand_coord();
        cz = rand_coord();
        ex = $urandom_range(0, 300);
        ey = $urandom_range(0, 300);
        ez = $urandom_range(0, 300);
        noisy = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          if (noisy)
            send_item(ACT_BOX, $urandom, $urandom, $urandom, rand_radius(), i == len - 1, FREE);
          else
            send_item(ACT_BOX, (i & 1) ? cx + ex : cx - ex, (i & 2) ? cy + ey : cy - ey,
                      (i & 4) ? cz + ez : cz - ez, rand_radius(), i == len - 1, FREE);
        end
        sent += len;
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result check and prediction on each transfer
  always @(posedge clk) begin : check_results
    logic [VERDICT_W-1:0] want_v, got_v;
    logic has;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_v = m_axis_tdata[VERDICT_W-1:0];
        if (verdict_q.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected verdict %0d at cycle %0d", got_v, cycle_count);
        end else begin
          want_v = verdict_q.pop_front();
          n_checked++;
          if (got_v !== want_v) begin
            failures++;
            if (failures <= 10)
              $display("verdict mismatch at cycle %0d: expected %0d, got %0d",
                       cycle_count, want_v, got_v);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ACT_POINT) n_points++;
        if (s_axis_tuser == ACT_SPHERE) n_spheres++;
        if (s_axis_tuser == ACT_BOX && s_axis_tlast) n_boxes++;
        cull_predict(s_axis_tuser, s_axis_tdata, s_axis_tlast, has, want_v);
        if (has) begin
          if (drv_want != FREE) want_v = VERDICT_W'(drv_want);
          verdict_q.push_back(want_v);
        end
      end
    end
  end

  // main sequence
  initial begin
    // reset planes are all zero: every distance is zero, so everything is inside
    add_case(ACT_POINT,  32767, -32768, 0, 0, 0, VERDICT_INSIDE);
    add_case(ACT_SPHERE, -32768, 32767, -1, 32767, 1, VERDICT_INSIDE);
    add_case(ACT_BOX,    -32768, -32768, 32767, 0, 1, VERDICT_INSIDE);
    add_case(ACT_UNUSED, 0, 0, 0, 0, 1, FREE);
    // axis-aligned cube of half size HALF
    add_case(ACT_POINT,  0, 0, 0, 0, 0, VERDICT_INSIDE);
    add_case(ACT_POINT,  HALF, -HALF, HALF, 0, 0, VERDICT_INSIDE);
    add_case(ACT_POINT,  HALF + 1, 0, 0, 0, 0, VERDICT_OUTSIDE);
    add_case(ACT_POINT,  -32768, -32768, -32768, 0, 1, VERDICT_OUTSIDE);
    add_case(ACT_POINT,  32767, 32767, 32767, 32767, 0, VERDICT_OUTSIDE);
    add_case(ACT_SPHERE, HALF + 40, 0, 0, 40, 0, VERDICT_INSIDE);
    add_case(ACT_SPHERE, HALF + 41, 0, 0, 40, 0, VERDICT_OUTSIDE);
    add_case(ACT_SPHERE, 32767, 32767, 32767, 32767, 0, VERDICT_INSIDE);
    add_case(ACT_SPHERE, -32768, 0, 0, 0, 1, VERDICT_OUTSIDE);
    // boxes: inside, straddling, fully out past one plane
    add_case(ACT_BOX,    -100, -100, -100, 0, 0, FREE);
    add_case(ACT_BOX,    100, 100, 100, 0, 1, VERDICT_INSIDE);
    add_case(ACT_BOX,    0, 0, 0, 0, 0, FREE);
    add_case(ACT_BOX,    300, 0, 0, 0, 1, VERDICT_INTERSECTS);
    add_case(ACT_BOX,    300, 0, 0, 0, 0, FREE);
    add_case(ACT_BOX,    400, 0, 0, 0, 1, VERDICT_OUTSIDE);
    // corners out on different planes still count as intersecting
    add_case(ACT_BOX,    300, 0, 0, 0, 0, FREE);
    add_case(ACT_BOX,    0, 300, 0, 0, 1, VERDICT_INTERSECTS);
    // unused code and a point inside an open box leave the flags alone
    add_case(ACT_BOX,    300, 0, 0, 0, 0, FREE);
    add_case(ACT_UNUSED, 0, 0, 0, 0, 1, FREE);
    add_case(ACT_POINT,  500, 0, 0, 0, 1, VERDICT_OUTSIDE);
    add_case(ACT_BOX,    0, 0, 0, 0, 1, VERDICT_INTERSECTS);
    // one-corner box, radius ignored
    add_case(ACT_BOX,    50, -50, 50, 32767, 1, VERDICT_INSIDE);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 9;
    recv_idle = 80;
    for (int i = 0; i < dir_cases.size(); i++) begin
      if (i == RESET_CASES) begin
        drain();
        load_planes(PLANES_CUBE);
      end
      send_item(dir_cases[i].act, dir_cases[i].x, dir_cases[i].y, dir_cases[i].z,
                dir_cases[i].r, dir_cases[i].last, dir_cases[i].want);
    end

    // random phases, each on a new plane set
    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle = (ph < 2) ? 9 : (ph < 4) ? 80 : 0;
      recv_idle = (ph < 2) ? 80 : (ph < 4) ? 9 : 0;
      drain();
      load_planes(phase_modes[ph]);
      send_random(RANDOM_ITEMS / PHASES);
    end
    drain();

    $display("sent %0d points, %0d spheres and %0d boxes over %0d plane settings",
             n_points, n_spheres, n_boxes, n_settings);
    $display("%0d verdicts compared, %0d failures", n_checked, failures);
    if (failures == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
